[hw/rtl/text_console_writer_core_macros.svh]
// ---------------------------------------------------------------------------
// text console writer assertion macros
// concurrent assertion wrappers, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(label, clk, rst, prop, msg)
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[hw/rtl/tcw_pkg.sv]
// ---------------------------------------------------------------------------
// text console writer package
// sizes, codes and the command/status bundles shared by the core modules
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int MAX_COLS   = 80;
  localparam int MAX_ROWS   = 25;
  localparam int CELLS      = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int CNT_W      = $clog2(CELLS + 1);
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CHAR_W-1:0] ATTR_TEXT    = 8'h0F;
  localparam logic [CHAR_W-1:0] ATTR_BLANK   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [COL_W-1:0] COLS_RESET = 7'd80;
  localparam logic [ROW_W-1:0] ROWS_RESET = 5'd25;

  typedef struct packed {
    logic clear_wr;
    logic load_in;
    logic exec;
    logic copy_rd;
    logic copy_wr;
    logic fill_wr;
    logic finish;
  } tcw_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_read;
    logic need_scroll;
    logic copy_done;
    logic fill_last;
    logic out_free;
  } tcw_sts_t;

endpackage

[hw/rtl/tcw_datapath.sv]
// ---------------------------------------------------------------------------
// text console writer datapath
// screen memory, cursor, size registers, scroll pointer and result register
// ---------------------------------------------------------------------------
`include "text_console_writer_core_macros.svh"

module tcw_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tcw_pkg::tcw_cmd_t             cmd,
  output tcw_pkg::tcw_sts_t             sts,
  input  logic                          in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char,
  input  logic [tcw_pkg::IDX_W-1:0]     in_index,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::CHAR_W-1:0]    out_char,
  output logic [tcw_pkg::CHAR_W-1:0]    out_attr,
  output logic [tcw_pkg::ROW_W-1:0]     out_row,
  output logic [tcw_pkg::COL_W-1:0]     out_col,
  output logic                          out_scrolled
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata;

  logic [COL_W-1:0]  columns;
  logic [ROW_W-1:0]  rows;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ADDR_W-1:0] ptr;

  logic              cmd_r;
  logic [CHAR_W-1:0] ch_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  keep_r;
  logic [CNT_W-1:0]  end_r;
  logic              scroll_r;
  logic              rd_ok;

  logic [COL_W-1:0]  nc;
  logic [ROW_W-1:0]  nr;
  logic [ROW_W-1:0]  row_c;
  logic [COL_W-1:0]  col_c;
  logic [CNT_W-1:0]  pos;
  logic [COL_W:0]    col_inc;
  logic [ROW_W-1:0]  base_row;
  logic [ROW_W:0]    row_inc;
  logic              is_nl;
  logic              advance;
  logic              need_scroll;
  logic [ROW_W-1:0]  row_new;
  logic [COL_W-1:0]  col_new;
  logic [CNT_W-1:0]  keep_full;
  logic [CNT_W-1:0]  end_full;
  logic              idx_in_range;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  // effective sizes
  always_comb begin
    if (columns == '0) begin
      nc = COL_W'(1);
    end else if (columns > MAX_COLS) begin
      nc = COL_W'(MAX_COLS);
    end else begin
      nc = columns;
    end
    if (rows == '0) begin
      nr = ROW_W'(1);
    end else if (rows > MAX_ROWS) begin
      nr = ROW_W'(MAX_ROWS);
    end else begin
      nr = rows;
    end
  end

  // cursor step for a put item
  always_comb begin
    row_c       = (cur_row >= nr) ? nr - 1'b1 : cur_row;
    col_c       = (cur_col >= nc) ? nc - 1'b1 : cur_col;
    pos         = CNT_W'(nc) * CNT_W'(row_c) + CNT_W'(col_c);
    col_inc     = {1'b0, col_c} + 1'b1;
    is_nl       = (ch_r == CHAR_NEWLINE);
    advance     = is_nl || (col_inc >= {1'b0, nc});
    base_row    = is_nl ? cur_row : row_c;
    row_inc     = {1'b0, base_row} + 1'b1;
    need_scroll = (cmd_r == CMD_PUT) && advance && (row_inc >= {1'b0, nr});
    if (need_scroll) begin
      row_new = nr - 1'b1;
    end else if (advance) begin
      row_new = row_inc[ROW_W-1:0];
    end else begin
      row_new = row_c;
    end
    col_new      = advance ? '0 : col_inc[COL_W-1:0];
    keep_full    = CNT_W'(nc) * CNT_W'(nr - 1'b1);
    end_full     = CNT_W'(nc) * CNT_W'(nr);
    idx_in_range = (idx_r < CELLS);
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = '0;
    re    = 1'b0;
    raddr = ADDR_W'(ptr + ADDR_W'(nc));
    if (cmd.clear_wr) begin
      we = 1'b1;
    end
    if (cmd.exec && cmd_r == CMD_PUT && !is_nl) begin
      we    = 1'b1;
      waddr = ADDR_W'(pos);
      wdata = {ATTR_TEXT, ch_r};
    end
    if (cmd.exec && cmd_r == CMD_READ && idx_in_range) begin
      re    = 1'b1;
      raddr = ADDR_W'(idx_r);
    end
    if (cmd.copy_rd) begin
      re = 1'b1;
    end
    if (cmd.copy_wr) begin
      we    = 1'b1;
      wdata = rdata;
    end
    if (cmd.fill_wr) begin
      we    = 1'b1;
      wdata = {ATTR_BLANK, CHAR_SPACE};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      columns   <= COLS_RESET;
      rows      <= ROWS_RESET;
      cur_row   <= '0;
      cur_col   <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec && cmd_r == CMD_PUT) begin
        cur_row <= row_new;
        cur_col <= col_new;
      end
      if (cfg_we && (cfg_index == REG_COLUMNS || cfg_index == REG_ROWS)) begin
        if (cfg_index == REG_COLUMNS) begin
          columns <= cfg_data[COL_W-1:0];
        end else begin
          rows <= cfg_data[ROW_W-1:0];
        end
        cur_row <= '0;
        cur_col <= '0;
      end
      if (cmd.exec) begin
        ptr <= '0;
      end else if (cmd.clear_wr || cmd.copy_wr || cmd.fill_wr) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_command;
      ch_r  <= in_char;
      idx_r <= in_index;
    end
    if (cmd.exec) begin
      keep_r   <= keep_full;
      end_r    <= end_full;
      scroll_r <= need_scroll;
      rd_ok    <= idx_in_range;
    end
    if (cmd.finish) begin
      out_char     <= (cmd_r == CMD_READ && rd_ok) ? rdata[CHAR_W-1:0] : '0;
      out_attr     <= (cmd_r == CMD_READ && rd_ok) ? rdata[CELL_W-1:CHAR_W] : '0;
      // a put finished in its execute cycle takes the new cursor directly
      out_row      <= cmd.exec ? row_new : cur_row;
      out_col      <= cmd.exec ? col_new : cur_col;
      out_scrolled <= (cmd_r == CMD_PUT) && (cmd.exec ? need_scroll : scroll_r);
    end
  end

  always_comb begin
    sts.clear_last  = (CNT_W'(ptr) == CNT_W'(CELLS - 1));
    sts.is_read     = (cmd_r == CMD_READ);
    sts.need_scroll = need_scroll;
    sts.copy_done   = (CNT_W'(ptr) >= keep_r);
    sts.fill_last   = (CNT_W'(ptr) == end_r - 1'b1);
    sts.out_free    = !out_valid || out_ready;
  end

  `TCW_ASSERT(a_cursor_bounds, clk, rst, (cur_row < nr) && (cur_col < nc), "cursor left the screen")
  `TCW_ASSERT(a_scroll_last_row, clk, rst, (out_valid && out_scrolled) |-> (out_row == nr - 1'b1), "scroll result not on last row")

endmodule

[hw/rtl/tcw_ctrl.sv]
// ---------------------------------------------------------------------------
// text console writer controller
// sequences clearing, item execution, scroll copy/fill and result hand-off
// ---------------------------------------------------------------------------
`include "text_console_writer_core_macros.svh"

module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RDATA,
    S_COPY_RD,
    S_COPY_WR,
    S_FILL,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_read) begin
          state_next = S_RDATA;
        end else if (sts.need_scroll) begin
          state_next = S_COPY_RD;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_COPY_RD: begin
        if (sts.copy_done) begin
          state_next = S_FILL;
        end else begin
          cmd.copy_rd = 1'b1;
          state_next  = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        state_next  = S_COPY_RD;
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) state_next = S_DONE;
      end
      S_RDATA, S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  `TCW_ASSERT(a_accept_exec, clk, rst, (in_valid && in_ready) |=> (state == S_EXEC), "transfer not followed by execute")
  `TCW_ASSERT(a_finish_free, clk, rst, cmd.finish |-> sts.out_free, "result loaded over a pending one")
  `TCW_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (state == S_CLEAR), "reset did not start clearing")

endmodule

[hw/rtl/text_console_writer_core.sv]
// ---------------------------------------------------------------------------
// text console writer core
// text-mode console with cursor, scroll and cell read-back
// ---------------------------------------------------------------------------
// After reset the core sweeps the 2000-cell screen memory to zero, one cell
// per cycle, and holds in_ready low until the sweep is done. A put or newline
// item then passes through transfer and execute, and a read adds a read-data
// step because the screen memory has a registered read. An item that scrolls
// then copies every kept cell one row up, reading it and writing it back in
// separate steps, and then fills the bottom row. A finished result sits in
// an output register, so the next item can be taken while it waits.
// ---------------------------------------------------------------------------
module text_console_writer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::IDX_W-1:0]      cell_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcw_pkg::CHAR_W-1:0]     cell_char,
  output logic [tcw_pkg::CHAR_W-1:0]     cell_attr,
  output logic [tcw_pkg::ROW_W-1:0]      cursor_row,
  output logic [tcw_pkg::COL_W-1:0]      cursor_col,
  output logic                           scrolled,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_command   (command),
    .in_char      (char_code),
    .in_index     (cell_index),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (cell_char),
    .out_attr     (cell_attr),
    .out_row      (cursor_row),
    .out_col      (cursor_col),
    .out_scrolled (scrolled)
  );

endmodule
